// File: src/mer_pkg.sv
// shared types and constants of the midpoint ellipse rasterizer
package mer_pkg;

  localparam int RADIUS_BITS_DEF = 10;
  localparam int COORD_BITS_DEF  = 11;
  localparam int COLOUR_BITS     = 4;
  localparam int CFG_IDX_BITS    = 2;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STEP  = 1'b1;

  localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_X = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_Y = 2'd1;

  localparam logic [1:0] BEAT_FIRST = 2'd0;
  localparam logic [1:0] BEAT_LAST  = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_A,
    ST_SQ_B,
    ST_AAB,
    ST_INIT,
    ST_P1,
    ST_P2,
    ST_FIN,
    ST_TX2,
    ST_BTX,
    ST_YM2,
    ST_AYM,
    ST_ADD,
    ST_SUB
  } ctrl_state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_START,
    OP_STEP,
    OP_SQ_A,
    OP_SQ_B,
    OP_AAB,
    OP_INIT,
    OP_P1,
    OP_P2,
    OP_FIN,
    OP_TX2,
    OP_BTX,
    OP_YM2,
    OP_AYM,
    OP_ADD,
    OP_SUB
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic       pix_load;
    logic [1:0] beat;
  } dp_cmd_t;

  typedef struct packed {
    logic step_done;
    logic to_region_two;
  } dp_stat_t;

endpackage

// File: src/mer_ctrl.sv
// sequencer of the ellipse rasterizer: operation schedule and pixel beats
module mer_ctrl
  import mer_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  logic     action_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output dp_cmd_t  cmd_o,
  input  dp_stat_t stat_i
);

  ctrl_state_e state_q, state_d;
  logic        active_q, active_d;
  logic        emit_q, emit_d;
  logic [1:0]  beat_q, beat_d;
  logic        out_valid_q, out_valid_d;
  logic        accept;
  logic        pix_load;
  dp_op_e      op;

  assign in_stall_o = !((state_q == ST_IDLE) && !emit_q);
  assign accept     = in_valid_i && !in_stall_o;

  // next state
  always_comb begin
    state_d  = state_q;
    active_d = active_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (action_i == ACT_START) begin
            state_d  = ST_SQ_A;
            active_d = 1'b1;
          end else if (active_q) begin
            if (stat_i.step_done) begin
              active_d = 1'b0;
            end else begin
              state_d = ST_P1;
            end
          end
        end
      end
      ST_SQ_A: state_d = ST_SQ_B;
      ST_SQ_B: state_d = ST_AAB;
      ST_AAB:  state_d = ST_INIT;
      ST_INIT: state_d = ST_IDLE;
      ST_P1:   state_d = ST_P2;
      ST_P2:   state_d = ST_FIN;
      ST_FIN: begin
        state_d = stat_i.to_region_two ? ST_TX2 : ST_IDLE;
      end
      ST_TX2:  state_d = ST_BTX;
      ST_BTX:  state_d = ST_YM2;
      ST_YM2:  state_d = ST_AYM;
      ST_AYM:  state_d = ST_ADD;
      ST_ADD:  state_d = ST_SUB;
      ST_SUB:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath operation per state
  always_comb begin
    op = OP_NONE;
    case (state_q)
      ST_IDLE: begin
        if (accept && (action_i == ACT_START)) begin
          op = OP_START;
        end else if (accept && active_q) begin
          op = OP_STEP;
        end
      end
      ST_SQ_A: op = OP_SQ_A;
      ST_SQ_B: op = OP_SQ_B;
      ST_AAB:  op = OP_AAB;
      ST_INIT: op = OP_INIT;
      ST_P1:   op = OP_P1;
      ST_P2:   op = OP_P2;
      ST_FIN:  op = OP_FIN;
      ST_TX2:  op = OP_TX2;
      ST_BTX:  op = OP_BTX;
      ST_YM2:  op = OP_YM2;
      ST_AYM:  op = OP_AYM;
      ST_ADD:  op = OP_ADD;
      ST_SUB:  op = OP_SUB;
      default: op = OP_NONE;
    endcase
  end

  // pixel beats into the output register
  always_comb begin
    pix_load    = emit_q && (!out_valid_q || !out_stall_i);
    emit_d      = emit_q;
    beat_d      = beat_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (pix_load) begin
      out_valid_d = 1'b1;
      beat_d      = beat_q + 2'd1;
      if (beat_q == BEAT_LAST) begin
        emit_d = 1'b0;
      end
    end
    if (accept && (action_i == ACT_STEP) && active_q) begin
      emit_d = 1'b1;
      beat_d = BEAT_FIRST;
    end
  end

  assign cmd_o       = {op, pix_load, beat_q};
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      active_q    <= 1'b0;
      emit_q      <= 1'b0;
      beat_q      <= BEAT_FIRST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      emit_q      <= emit_d;
      beat_q      <= beat_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef ASSERT_OFF
  a_beat_in_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (beat_q != BEAT_FIRST) |-> emit_q)
    else $error("beat counter running outside a pixel burst");

  a_active_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(active_q) |-> $past(accept && (action_i == ACT_STEP)))
    else $error("ellipse ended without a step beat");

  a_step_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (action_i == ACT_STEP) && active_q) |=> emit_q)
    else $error("active step did not start a pixel burst");

  a_switch_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TX2) |-> $past(state_q == ST_FIN))
    else $error("region switch entered out of sequence");
`endif

endmodule

// File: src/mer_datapath.sv
// walker registers, shared multiplier, decision accumulator and pixel output register
module mer_datapath
  import mer_pkg::*;
#(
  parameter int RADIUS_BITS = RADIUS_BITS_DEF,
  parameter int COORD_BITS  = COORD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]       cfg_index_i,
  input  logic [COORD_BITS-1:0]         cfg_wdata_i,
  input  logic [RADIUS_BITS-1:0]        radius_x_i,
  input  logic [RADIUS_BITS-1:0]        radius_y_i,
  input  logic [COLOUR_BITS-1:0]        colour_i,
  input  dp_cmd_t                       cmd_i,
  output dp_stat_t                      stat_o,
  output logic signed [COORD_BITS+1:0]  pixel_x_o,
  output logic signed [COORD_BITS+1:0]  pixel_y_o,
  output logic [COLOUR_BITS-1:0]        pixel_colour_o,
  output logic                          last_pixel_o
);

  localparam int R  = RADIUS_BITS;
  localparam int MA = 2 * R;
  localparam int MB = 2 * R + 4;
  localparam int PW = MA + MB;
  localparam int DW = 4 * R + 8;
  localparam int CW = 3 * R + 1;
  localparam int OW = COORD_BITS + 2;

  logic [COORD_BITS-1:0]  cx_q, cy_q;
  logic [R-1:0]           ra_q, rb_q;
  logic [COLOUR_BITS-1:0] colour_q;
  logic [MA-1:0]          a2_q, b2_q;
  logic [R:0]             x_q, y_q;
  logic [DW-1:0]          d_q;
  logic                   reg2_q;
  logic [PW-1:0]          prod_q;
  logic [CW-1:0]          keep_q;
  logic [R:0]             px_q;
  logic [R-1:0]           py_q;
  logic                   pr2_q, pdone_q, dneg_q;
  logic [OW-1:0]          pix_x_q, pix_y_q;
  logic [COLOUR_BITS-1:0] pix_col_q;
  logic                   pix_last_q;

  logic [MA-1:0] op_a;
  logic [MB-1:0] op_b;
  logic [PW-1:0] mul_out;
  logic [DW-1:0] prod_ext;
  logic [R:0]    x_next, y_next;
  logic          dneg, inc_x, dec_y;
  logic [R+1:0]  tx;
  logic [R-1:0]  ym;
  logic          use_p1, use_p2, gt;
  logic          neg_x, neg_y;
  logic [OW-1:0] off_x, off_y;

  // step of the walker, decided by the sign of the scaled decision
  assign dneg   = d_q[DW-1];
  assign inc_x  = reg2_q ? dneg : 1'b1;
  assign dec_y  = reg2_q ? 1'b1 : !dneg;
  assign x_next = x_q + {{R{1'b0}}, inc_x};
  assign y_next = y_q - {{R{1'b0}}, dec_y};

  assign tx = {x_q, 1'b1};
  assign ym = (y_q[R-1:0] == '0) ? {{(R-1){1'b0}}, 1'b1} : y_q[R-1:0] - {{(R-1){1'b0}}, 1'b1};

  assign use_p1 = reg2_q ? dneg_q : 1'b1;
  assign use_p2 = reg2_q ? 1'b1 : !dneg_q;
  assign gt     = keep_q > prod_q[CW-1:0];

  assign stat_o.step_done     = y_next[R];
  assign stat_o.to_region_two = (cmd_i.op == OP_FIN) && !reg2_q && gt;

  // shared multiplier operands
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd_i.op)
      OP_SQ_A: begin
        op_a = MA'(ra_q);
        op_b = MB'(ra_q);
      end
      OP_SQ_B: begin
        op_a = MA'(rb_q);
        op_b = MB'(rb_q);
      end
      OP_AAB: begin
        op_a = a2_q;
        op_b = MB'(rb_q);
      end
      OP_P1: begin
        op_a = b2_q;
        op_b = MB'(x_q);
      end
      OP_P2: begin
        op_a = a2_q;
        op_b = MB'(y_q[R-1:0]);
      end
      OP_TX2: begin
        op_a = MA'(tx);
        op_b = MB'(tx);
      end
      OP_BTX: begin
        op_a = b2_q;
        op_b = prod_q[MB-1:0];
      end
      OP_YM2: begin
        op_a = MA'(ym);
        op_b = MB'(ym);
      end
      OP_AYM: begin
        op_a = a2_q;
        op_b = prod_q[MB-1:0];
      end
      OP_ADD: begin
        op_a = a2_q;
        op_b = MB'(b2_q);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign mul_out  = {{MB{1'b0}}, op_a} * {{MA{1'b0}}, op_b};
  assign prod_ext = DW'(prod_q);

  // mirror signs per beat, order depends on the region of the emitted point
  always_comb begin
    if (!pr2_q) begin
      neg_x = (cmd_i.beat == 2'd1) || (cmd_i.beat == 2'd2);
      neg_y = (cmd_i.beat == 2'd2) || (cmd_i.beat == 2'd3);
    end else begin
      neg_x = (cmd_i.beat == 2'd2) || (cmd_i.beat == 2'd3);
      neg_y = (cmd_i.beat == 2'd1) || (cmd_i.beat == 2'd2);
    end
    off_x = neg_x ? ({OW{1'b0}} - OW'(px_q)) : OW'(px_q);
    off_y = neg_y ? ({OW{1'b0}} - OW'(py_q)) : OW'(py_q);
  end

  // center registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= '0;
      cy_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_CENTER_X) begin
        cx_q <= cfg_wdata_i;
      end else if (cfg_index_i == CFG_CENTER_Y) begin
        cy_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg2_q <= 1'b0;
    end else if (cmd_i.op == OP_START) begin
      reg2_q <= 1'b0;
    end else if (stat_o.to_region_two) begin
      reg2_q <= 1'b1;
    end
  end

  // walker, multiplier and accumulator
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_START: begin
        ra_q     <= radius_x_i;
        rb_q     <= radius_y_i;
        colour_q <= colour_i;
        x_q      <= '0;
        y_q      <= {1'b0, radius_y_i};
      end
      OP_STEP: begin
        x_q     <= x_next;
        y_q     <= y_next;
        px_q    <= x_q;
        py_q    <= y_q[R-1:0];
        pr2_q   <= reg2_q;
        pdone_q <= y_next[R];
        dneg_q  <= dneg;
      end
      OP_SQ_A: a2_q <= mul_out[MA-1:0];
      OP_SQ_B: b2_q <= mul_out[MA-1:0];
      OP_AAB:  prod_q <= mul_out;
      OP_INIT: d_q <= (DW'(b2_q) << 2) + DW'(a2_q) - (prod_ext << 2);
      OP_P1:   prod_q <= mul_out;
      OP_P2: begin
        prod_q <= mul_out;
        keep_q <= prod_q[CW-1:0];
        d_q    <= d_q + (use_p1 ? (prod_ext << 3) : {DW{1'b0}})
                      + (reg2_q ? (DW'(a2_q) << 2) : (DW'(b2_q) << 2));
      end
      OP_FIN:  d_q <= d_q - (use_p2 ? (prod_ext << 3) : {DW{1'b0}});
      OP_TX2:  prod_q <= mul_out;
      OP_BTX:  prod_q <= mul_out;
      OP_YM2: begin
        prod_q <= mul_out;
        d_q    <= prod_ext;
      end
      OP_AYM:  prod_q <= mul_out;
      OP_ADD: begin
        prod_q <= mul_out;
        d_q    <= d_q + (prod_ext << 2);
      end
      OP_SUB:  d_q <= d_q - (prod_ext << 2);
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.pix_load) begin
      pix_x_q    <= OW'(cx_q) + off_x;
      pix_y_q    <= OW'(cy_q) + off_y;
      pix_col_q  <= colour_q;
      pix_last_q <= (cmd_i.beat == BEAT_LAST) && pdone_q;
    end
  end

  assign pixel_x_o      = $signed(pix_x_q);
  assign pixel_y_o      = $signed(pix_y_q);
  assign pixel_colour_o = pix_col_q;
  assign last_pixel_o   = pix_last_q;

`ifndef ASSERT_OFF
  a_fin_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_FIN) |-> !y_q[R])
    else $error("decision update on a finished ellipse");

  a_region_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(reg2_q) |-> $past(cmd_i.op == OP_FIN))
    else $error("region two entered outside the switch check");

  a_last_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.pix_load && (cmd_i.beat != BEAT_LAST)) |=> !pix_last_q)
    else $error("last pixel flag on an inner beat");
`endif

endmodule

// File: src/midpoint_ellipse_rasterizer.sv
// top level of the midpoint ellipse rasterizer
// Two-region midpoint ellipse walker with four-way symmetry. A start beat
// (action 0) latches radius_x, radius_y and colour, then squares the radii
// and seeds the scaled decision term, during which no beat is accepted. A
// step beat (action 1) on a running ellipse yields four mirrored pixels
// around the center registers, one per cycle through a registered output
// while out_stall is low; in parallel the decision term is updated on a
// single shared multiplier in steps P1, P2 and FIN, plus TX2, BTX, YM2, AYM,
// ADD and SUB on the step that crosses from region one into region two. The
// next beat is taken once the update is done and the last of the four
// pixels sits in the output register. The last pixel of the step that ends
// the ellipse (y below zero) carries last_pixel. Steps on an idle block are
// taken and dropped, a start during a running ellipse restarts it. center_x
// and center_y are written at indexes 0 and 1 of the config port; the user
// must do so only while the block is idle, which the block itself does not enforce.
module midpoint_ellipse_rasterizer
  import mer_pkg::*;
#(
  parameter int RADIUS_BITS = RADIUS_BITS_DEF,
  parameter int COORD_BITS  = COORD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config write port
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]       cfg_index_i,
  input  logic [COORD_BITS-1:0]         cfg_wdata_i,
  // command beats
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          action_i,
  input  logic [RADIUS_BITS-1:0]        radius_x_i,
  input  logic [RADIUS_BITS-1:0]        radius_y_i,
  input  logic [COLOUR_BITS-1:0]        colour_i,
  // pixel beats
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [COORD_BITS+1:0]  pixel_x_o,
  output logic signed [COORD_BITS+1:0]  pixel_y_o,
  output logic [COLOUR_BITS-1:0]        pixel_colour_o,
  output logic                          last_pixel_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // schedule of datapath operations and pixel beats
  mer_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  // walker state, shared multiplier, accumulator and output register
  mer_datapath #(
    .RADIUS_BITS (RADIUS_BITS),
    .COORD_BITS  (COORD_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .radius_x_i     (radius_x_i),
    .radius_y_i     (radius_y_i),
    .colour_i       (colour_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .pixel_x_o      (pixel_x_o),
    .pixel_y_o      (pixel_y_o),
    .pixel_colour_o (pixel_colour_o),
    .last_pixel_o   (last_pixel_o)
  );

endmodule
